// ===== rtl/iee_pkg.sv =====
// shared types, constants and byte escaping function for the ini escape encoder
`timescale 1ns / 1ps

package iee_pkg;

    // string kind codes
    localparam logic [1:0] KIND_GROUP = 2'd0;
    localparam logic [1:0] KIND_KEY   = 2'd1;
    localparam logic [1:0] KIND_VALUE = 2'd2;
    localparam logic [1:0] KIND_RESET = KIND_VALUE;

    // character codes
    localparam logic [7:0] CHAR_NL     = 8'h0a;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0d;
    localparam logic [7:0] CHAR_BSLASH = 8'h5c;
    localparam logic [7:0] CHAR_EQUAL  = 8'h3d;
    localparam logic [7:0] CHAR_LBRACK = 8'h5b;
    localparam logic [7:0] CHAR_RBRACK = 8'h5d;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_LOW_S  = 8'h73;
    localparam logic [7:0] CHAR_LOW_N  = 8'h6e;
    localparam logic [7:0] CHAR_LOW_T  = 8'h74;
    localparam logic [7:0] CHAR_LOW_R  = 8'h72;
    localparam logic [7:0] CHAR_LOW_X  = 8'h78;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;
    localparam logic [7:0] CTRL_LIMIT  = 8'd32;
    localparam logic [3:0] NIBBLE_MASK = 4'hf;

    // escape sequence of one to four bytes, byte 0 goes out first
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      len_m1;
    } esc_seq_t;

    // lowercase hex digit
    function automatic logic [7:0] hex_digit(logic [3:0] n);
        logic [7:0] d;
        if (n < 4'd10)
            d = 8'(CHAR_ZERO + {4'h0, n});
        else
            d = 8'(CHAR_LOW_A + {4'h0, n} - 8'd10);
        return d;
    endfunction

    // escape one byte under the given kind and string position
    function automatic esc_seq_t encode_byte(logic [7:0] c, logic first, logic last,
                                             logic [1:0] kind);
        esc_seq_t s;
        logic     hex;
        logic     pair;
        logic [7:0] letter;
        hex    = 1'b0;
        pair   = 1'b0;
        letter = CHAR_LOW_S;
        if (c == CHAR_SPACE && kind != KIND_GROUP && (first || last))
        begin
            pair = 1'b1;
        end
        else
        begin
            case (c)
                CHAR_NL:     begin pair = 1'b1; letter = CHAR_LOW_N;  end
                CHAR_TAB:    begin pair = 1'b1; letter = CHAR_LOW_T;  end
                CHAR_CR:     begin pair = 1'b1; letter = CHAR_LOW_R;  end
                CHAR_BSLASH: begin pair = 1'b1; letter = CHAR_BSLASH; end
                CHAR_EQUAL:  hex = (kind == KIND_KEY);
                CHAR_LBRACK: hex = (kind != KIND_VALUE);
                CHAR_RBRACK: hex = (kind != KIND_VALUE);
                default:     hex = (c < CTRL_LIMIT);
            endcase
        end
        s.bytes = '0;
        if (hex)
        begin
            s.bytes[0] = CHAR_BSLASH;
            s.bytes[1] = CHAR_LOW_X;
            s.bytes[2] = hex_digit(c[7:4] & NIBBLE_MASK);
            s.bytes[3] = hex_digit(c[3:0] & NIBBLE_MASK);
            s.len_m1   = 2'd3;
        end
        else if (pair)
        begin
            s.bytes[0] = CHAR_BSLASH;
            s.bytes[1] = letter;
            s.len_m1   = 2'd1;
        end
        else
        begin
            s.bytes[0] = c;
            s.len_m1   = 2'd0;
        end
        return s;
    endfunction

endpackage

// ===== rtl/ini_escape_encoder_unit.sv =====
// An item goes through the input register and the output sequence register
// before its first byte appears. The output sequence register sets the rate,
// one byte per cycle while out_stall is low: a literal byte is one output
// byte, so plain text streams at one item per cycle; a backslash pair holds
// the register for two bytes and a hex escape for four, during which the
// input register fills and then stalls. The string kind register is written
// through the cfg port (always ready) and resets to value mode; write it only
// while no item is in flight. Beginning of a string is tracked from the last
// flag of the previous item; reset starts a new string.
`timescale 1ns / 1ps

module ini_escape_encoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    // configuration write
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] string_kind,
    // input items
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_char,
    input  logic       in_last,
    // output items
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       run_last,
    output logic       string_end
);

    logic [1:0] kind_reg;
    logic       start_reg;

    logic       in_vld_reg,   in_vld_next;
    logic [7:0] in_char_reg;
    logic       in_last_reg;
    logic       in_first_reg;

    logic                    seq_vld_reg, seq_vld_next;
    iee_pkg::esc_seq_t       seq_reg;
    logic [1:0]              seq_idx_reg, seq_idx_next;
    logic                    seq_last_reg;

    iee_pkg::esc_seq_t enc;
    logic in_fire;
    logic out_fire;
    logic last_beat;
    logic seq_free;
    logic load;

    // handshake
    assign cfg_ready = 1'b1;
    assign last_beat = (seq_idx_reg == seq_reg.len_m1);
    assign out_fire  = seq_vld_reg && !out_stall;
    assign seq_free  = !seq_vld_reg || (out_fire && last_beat);
    assign load      = in_vld_reg && seq_free;
    assign in_stall  = in_vld_reg && !seq_free;
    assign in_fire   = in_valid && !in_stall;

    // escape the registered item
    assign enc = iee_pkg::encode_byte(in_char_reg, in_first_reg, in_last_reg, kind_reg);

    // output view of the sequence register
    assign out_valid  = seq_vld_reg;
    assign out_char   = seq_reg.bytes[seq_idx_reg];
    assign run_last   = last_beat;
    assign string_end = last_beat && seq_last_reg;

    // next control state
    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_fire)
            in_vld_next = 1'b1;
        else if (load)
            in_vld_next = 1'b0;

        seq_vld_next = seq_vld_reg;
        seq_idx_next = seq_idx_reg;
        if (load)
        begin
            seq_vld_next = 1'b1;
            seq_idx_next = 2'd0;
        end
        else if (out_fire)
        begin
            if (last_beat)
                seq_vld_next = 1'b0;
            else
                seq_idx_next = seq_idx_reg + 2'd1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg    <= iee_pkg::KIND_RESET;
            start_reg   <= 1'b1;
            in_vld_reg  <= 1'b0;
            seq_vld_reg <= 1'b0;
            seq_idx_reg <= 2'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                kind_reg <= string_kind;
            if (in_fire)
                start_reg <= in_last;
            in_vld_reg  <= in_vld_next;
            seq_vld_reg <= seq_vld_next;
            seq_idx_reg <= seq_idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_char_reg  <= in_char;
            in_last_reg  <= in_last;
            in_first_reg <= start_reg;
        end
        if (load)
        begin
            seq_reg      <= enc;
            seq_last_reg <= in_last_reg;
        end
    end

    // checks
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        seq_vld_reg |-> (seq_idx_reg <= seq_reg.len_m1))
        else $error("sequence index beyond escape length");

    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && string_end) |-> run_last)
        else $error("string end without run last");

    a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !seq_free) |=> (in_vld_reg && $stable(in_char_reg)))
        else $error("held input item lost");

    a_escape_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !last_beat) |=> (seq_vld_reg && seq_idx_reg == $past(seq_idx_reg) + 2'd1))
        else $error("escape sequence did not advance");

endmodule
